>>> rtl/u8cw_pkg.sv
// shared constants and the full-width range check for the utf-8 cell width counter
package u8cw_pkg;

    // apb register map
    localparam int unsigned APB_ADDR_BITS = 3;
    localparam int unsigned APB_DATA_BITS = 32;
    localparam logic        REG_TRUNCATE_LIMIT = 1'b0;   // word index of the only register

    localparam logic [15:0] LIMIT_RESET = 16'd20;
    localparam logic [15:0] ELLIPSIS_MIN = 16'd4;
    localparam logic [15:0] KEEP_MARGIN = 16'd3;

    // lead byte ranges
    localparam logic [7:0] LEAD2_MIN = 8'hC2;
    localparam logic [7:0] LEAD2_MAX = 8'hDF;
    localparam logic [7:0] LEAD3_MIN = 8'hE0;
    localparam logic [7:0] LEAD3_MAX = 8'hEF;
    localparam logic [7:0] LEAD4_MIN = 8'hF0;
    localparam logic [7:0] LEAD4_MAX = 8'hF4;

    localparam logic [7:0] CONT_MASK = 8'hC0;
    localparam logic [7:0] CONT_TAG = 8'h80;
    localparam logic [20:0] CONT_CHAR = 21'h000080;
    localparam logic [20:0] BMP_MAX = 21'h00FFFF;

    localparam logic [1:0] NEED_TWO = 2'd1;
    localparam logic [1:0] NEED_THREE = 2'd2;
    localparam logic [1:0] NEED_FOUR = 2'd3;

    function automatic logic is_wide(logic [20:0] cp);
        return (cp >= 21'h001100 && cp <= 21'h00115F) ||
               (cp >= 21'h002E80 && cp <= 21'h00A4CF) ||
               (cp >= 21'h00AC00 && cp <= 21'h00D7A3) ||
               (cp >= 21'h00F900 && cp <= 21'h00FAFF) ||
               (cp >= 21'h00FE10 && cp <= 21'h00FE19) ||
               (cp >= 21'h00FE30 && cp <= 21'h00FE6F) ||
               (cp >= 21'h00FF00 && cp <= 21'h00FF60) ||
               (cp >= 21'h00FFE0 && cp <= 21'h00FFE6);
    endfunction

endpackage

>>> rtl/u8cw_if.sv
// byte request and result channel interfaces of the utf-8 cell width counter
interface u8cw_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       byte_valid;
    logic       last;

    modport source (output valid, text_byte, byte_valid, last, input ready);
    modport sink (input valid, text_byte, byte_valid, last, output ready);
endinterface

interface u8cw_result_if;
    logic        valid;
    logic        ready;
    logic [15:0] display_width;
    logic [15:0] utf16_length;
    logic        truncated;
    logic [15:0] kept_bytes;
    logic        add_ellipsis;

    modport source (output valid, display_width, utf16_length, truncated, kept_bytes,
                    add_ellipsis, input ready);
    modport sink (input valid, display_width, utf16_length, truncated, kept_bytes,
                  add_ellipsis, output ready);
endinterface

>>> rtl/utf8_cell_width_and_truncation.sv
// utf-8 cell width counter: top level with decode, counters and truncation cut
// One byte request is taken every cycle, save while a last request waits as told below.
// Each request lands in an input register and is decoded and folded into the cell counters
// as it leaves that register; a last request leaving it also loads the result register.
// The throughput of one byte per cycle is set by that single register-to-register update,
// which handles a broken sequence (up to four characters at once) in the same cycle. A last
// request waits in the input register, and holds off further requests, while an earlier
// result is still untaken; requests that do not close a cell are never held. There is no
// clearing pass after reset. The limit register sits at byte address 0 of the apb port.
module utf8_cell_width_and_truncation #(
    parameter int unsigned COUNT_BITS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    u8cw_byte_if.sink                              bytes,
    u8cw_result_if.source                          result,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [u8cw_pkg::APB_ADDR_BITS-1:0]     paddr,
    input  logic [u8cw_pkg::APB_DATA_BITS-1:0]     pwdata,
    output logic [u8cw_pkg::APB_DATA_BITS-1:0]     prdata,
    output logic                                   pready
);

    localparam int unsigned CB = COUNT_BITS;
    localparam int unsigned EW = CB + 1;
    localparam int unsigned CW = (CB >= 16) ? CB + 1 : 17;
    localparam logic [CB-1:0] CMAX = '1;

    typedef struct packed {
        logic [7:0]    lead;
        logic [1:0]    needed;
        logic [1:0]    seen;
        logic [20:0]   code;
        logic [CB-1:0] seq_start;
        logic [CB-1:0] byte_off;
        logic [CB-1:0] unit;
        logic [CB-1:0] column;
        logic [CB-1:0] cut_off;
        logic          cut_frozen;
    } cell_t;

    function automatic logic [CB-1:0] sat_inc(logic [CB-1:0] v);
        return (v == CMAX) ? v : v + 1'b1;
    endfunction

    function automatic logic [CB-1:0] sat_add(logic [CB-1:0] v, logic [1:0] d);
        logic [CB:0] s;
        s = {1'b0, v} + EW'(d);
        return s[CB] ? CMAX : s[CB-1:0];
    endfunction

    function automatic logic [CB-1:0] clamp_end(logic [CB:0] e);
        return e[CB] ? CMAX : e[CB-1:0];
    endfunction

    function automatic logic [15:0] out16(logic [CB-1:0] v);
        logic [CW-1:0] w;
        w = CW'(v);
        return (w > CW'(17'h0FFFF)) ? 16'hFFFF : w[15:0];
    endfunction

    function automatic cell_t take_char(cell_t c, logic [20:0] cp, logic [CB:0] end_at,
                                        logic [15:0] lim);
        logic [1:0]    units;
        logic [1:0]    cols;
        logic [15:0]   keep;
        logic [CW-1:0] sum;
        cell_t         r;
        r = c;
        units = (cp > u8cw_pkg::BMP_MAX) ? 2'd2 : 2'd1;
        cols = units + {1'b0, u8cw_pkg::is_wide(cp)};
        keep = (lim < u8cw_pkg::ELLIPSIS_MIN) ? lim : lim - u8cw_pkg::KEEP_MARGIN;
        sum = CW'(c.unit) + CW'(units);
        if (lim != 16'd0 && !c.cut_frozen)
        begin
            if (sum <= CW'(keep))
                r.cut_off = clamp_end(end_at);
            else
                r.cut_frozen = 1'b1;
        end
        r.unit = sat_add(c.unit, units);
        r.column = sat_add(c.column, cols);
        return r;
    endfunction

    // lead and each continuation seen so far become one-unit characters
    function automatic cell_t flush_open(cell_t c, logic [15:0] lim);
        cell_t r;
        r = c;
        if (c.needed != 2'd0)
        begin
            r = take_char(r, {13'd0, c.lead}, {1'b0, c.seq_start} + EW'(1), lim);
            for (int i = 0; i < 2; i++)
            begin
                if (2'(i) < c.seen)
                    r = take_char(r, u8cw_pkg::CONT_CHAR, {1'b0, c.seq_start} + EW'(2 + i), lim);
            end
            r.needed = 2'd0;
            r.seen = 2'd0;
            r.code = 21'd0;
        end
        return r;
    endfunction

    // configuration
    logic [15:0] limit_reg;
    logic        cfg_write;

    assign pready = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == u8cw_pkg::REG_TRUNCATE_LIMIT);
    assign prdata = (paddr[2] == u8cw_pkg::REG_TRUNCATE_LIMIT) ?
                    {16'd0, limit_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= u8cw_pkg::LIMIT_RESET;
        else if (cfg_write)
            limit_reg <= pwdata[15:0];
    end

    // input register
    logic       s1_valid_reg;
    logic       s1_valid_next;
    logic [7:0] s1_byte_reg;
    logic       s1_bv_reg;
    logic       s1_last_reg;
    logic       s1_go;
    logic       take_req;

    assign s1_go = s1_valid_reg && (!s1_last_reg || !result.valid || result.ready);
    assign bytes.ready = !s1_valid_reg || s1_go;
    assign take_req = bytes.valid && bytes.ready;

    always_comb
    begin
        if (take_req)
            s1_valid_next = 1'b1;
        else if (s1_go)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take_req)
        begin
            s1_byte_reg <= bytes.text_byte;
            s1_bv_reg <= bytes.byte_valid;
            s1_last_reg <= bytes.last;
        end
    end

    // decode and counter update
    cell_t       cell_reg;
    cell_t       cell_next;
    logic [15:0] disp_next;
    logic [15:0] len_next;
    logic        trunc_next;
    logic [15:0] kept_next;
    logic        ell_next;

    always_comb
    begin
        cell_t      c;
        logic [7:0] b;
        logic       cut;
        c = cell_reg;
        b = s1_byte_reg;
        if (s1_bv_reg)
        begin
            if (c.needed != 2'd0 && (b & u8cw_pkg::CONT_MASK) == u8cw_pkg::CONT_TAG)
            begin
                c.code = {c.code[14:0], b[5:0]};
                c.seen = c.seen + 2'd1;
                if (c.seen == c.needed)
                begin
                    c = take_char(c, c.code, {1'b0, c.byte_off} + EW'(1), limit_reg);
                    c.needed = 2'd0;
                    c.seen = 2'd0;
                    c.code = 21'd0;
                end
            end
            else
            begin
                c = flush_open(c, limit_reg);
                if (b >= u8cw_pkg::LEAD2_MIN && b <= u8cw_pkg::LEAD2_MAX)
                begin
                    c.needed = u8cw_pkg::NEED_TWO;
                    c.code = {16'd0, b[4:0]};
                end
                else if (b >= u8cw_pkg::LEAD3_MIN && b <= u8cw_pkg::LEAD3_MAX)
                begin
                    c.needed = u8cw_pkg::NEED_THREE;
                    c.code = {17'd0, b[3:0]};
                end
                else if (b >= u8cw_pkg::LEAD4_MIN && b <= u8cw_pkg::LEAD4_MAX)
                begin
                    c.needed = u8cw_pkg::NEED_FOUR;
                    c.code = {18'd0, b[2:0]};
                end
                else
                begin
                    c = take_char(c, {13'd0, b}, {1'b0, c.byte_off} + EW'(1), limit_reg);
                end
                if (c.needed != 2'd0)
                begin
                    c.lead = b;
                    c.seen = 2'd0;
                    c.seq_start = c.byte_off;
                end
            end
            c.byte_off = sat_inc(c.byte_off);
        end

        // close of the cell: a sequence still open is split up
        if (s1_last_reg)
            c = flush_open(c, limit_reg);
        cut = (limit_reg != 16'd0) && (CW'(c.unit) > CW'(limit_reg));
        disp_next = out16(c.column);
        len_next = out16(c.unit);
        trunc_next = cut;
        kept_next = out16(cut ? c.cut_off : c.byte_off);
        ell_next = cut && (limit_reg >= u8cw_pkg::ELLIPSIS_MIN);
        cell_next = s1_last_reg ? '0 : c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cell_reg <= '0;
        else if (s1_go)
            cell_reg <= cell_next;
    end

    // result register
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [15:0] disp_reg;
    logic [15:0] len_reg;
    logic        trunc_reg;
    logic [15:0] kept_reg;
    logic        ell_reg;
    logic        load_out;

    assign load_out = s1_go && s1_last_reg;

    always_comb
    begin
        if (load_out)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            disp_reg <= disp_next;
            len_reg <= len_next;
            trunc_reg <= trunc_next;
            kept_reg <= kept_next;
            ell_reg <= ell_next;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.display_width = disp_reg;
    assign result.utf16_length = len_reg;
    assign result.truncated = trunc_reg;
    assign result.kept_bytes = kept_reg;
    assign result.add_ellipsis = ell_reg;

endmodule

>>> rtl/u8cw_checker.sv
// port-level checks for the utf-8 cell width counter and their binding
module u8cw_checker (
    input logic           clk,
    input logic           rst_n,
    u8cw_byte_if.sink     bytes,
    u8cw_result_if.source result
);

    // a waiting result holds still
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.ready |=> result.valid &&
        $stable(result.display_width) && $stable(result.utf16_length) &&
        $stable(result.truncated) && $stable(result.kept_bytes) &&
        $stable(result.add_ellipsis))
    else $error("result changed while stalled");

    a_result_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(result.valid) |-> $past(result.ready))
    else $error("result dropped without being taken");

    // byte requests only back up behind an untaken result
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !bytes.ready |-> result.valid)
    else $error("byte request stalled with no result pending");

    a_ellipsis: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.add_ellipsis |->
        result.truncated && (result.utf16_length >= 16'd5))
    else $error("ellipsis without a truncation past the limit");

    a_width_order: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> result.display_width >= result.utf16_length)
    else $error("display width below utf-16 length");

endmodule

bind utf8_cell_width_and_truncation u8cw_checker u_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .bytes  (bytes),
    .result (result)
);

>>> tb/testbench.sv
// self-checking testbench of the utf-8 cell width and truncation counter
module testbench;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       byte_valid;
        logic       last;
    } byte_req_t;

    typedef struct packed {
        logic [15:0] display_width;
        logic [15:0] utf16_length;
        logic        truncated;
        logic [15:0] kept_bytes;
        logic        add_ellipsis;
    } cell_width_t;

    localparam int SETTLE_CYCLES = 8;
    localparam int NUM_PHASES = 10;
    localparam int PHASE_ITEMS = 135;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    u8cw_byte_if   byte_ch ();
    u8cw_result_if result_ch ();

    logic                               psel;
    logic                               penable;
    logic                               pwrite;
    logic [u8cw_pkg::APB_ADDR_BITS-1:0] paddr;
    logic [u8cw_pkg::APB_DATA_BITS-1:0] pwdata;
    logic [u8cw_pkg::APB_DATA_BITS-1:0] prdata;
    logic                               pready;

    utf8_cell_width_and_truncation DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .bytes   (byte_ch),
        .result  (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    byte_req_t   pending_reqs[$];
    byte_req_t   cell_buf[$];
    cell_width_t expected_widths[$];

    int          errors = 0;
    int          cells_checked = 0;
    int          queued_items = 0;
    int          src_idle_pct = 0;
    int          sink_stall_pct = 0;
    int          src_gap = 0;
    int          sink_stall = 0;
    logic        req_fire;
    byte_req_t   drv_req;
    byte_req_t   mon_req;
    cell_width_t mon_width;

    // predictor copy of the limit register and of the cell state
    logic [15:0] limit_shadow;
    logic [7:0]  open_lead;
    logic [1:0]  open_need;
    logic [1:0]  open_seen;
    logic [20:0] open_code;
    logic [15:0] open_from;
    logic [15:0] byte_pos;
    logic [15:0] units;
    logic [15:0] columns;
    logic [15:0] cut_at;
    logic        cut_done;

    function automatic logic [15:0] range_lo(input int i);
        case (i)
            0:       return 16'h1100;
            1:       return 16'h2E80;
            2:       return 16'hAC00;
            3:       return 16'hF900;
            4:       return 16'hFE10;
            5:       return 16'hFE30;
            6:       return 16'hFF00;
            default: return 16'hFFE0;
        endcase
    endfunction

    function automatic logic [15:0] range_hi(input int i);
        case (i)
            0:       return 16'h115F;
            1:       return 16'hA4CF;
            2:       return 16'hD7A3;
            3:       return 16'hFAFF;
            4:       return 16'hFE19;
            5:       return 16'hFE6F;
            6:       return 16'hFF60;
            default: return 16'hFFE6;
        endcase
    endfunction

    function automatic logic wide_char(input logic [20:0] cp);
        for (int i = 0; i < 8; i++)
            if (cp >= 21'(range_lo(i)) && cp <= 21'(range_hi(i)))
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic logic [15:0] sat16(input logic [17:0] v);
        return (v > 18'h0FFFF) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic void clear_open();
        open_need = 2'd0;
        open_seen = 2'd0;
        open_code = 21'd0;
    endfunction

    function automatic void clear_cell();
        clear_open();
        open_lead = 8'd0;
        open_from = 16'd0;
        byte_pos = 16'd0;
        units = 16'd0;
        columns = 16'd0;
        cut_at = 16'd0;
        cut_done = 1'b0;
    endfunction

    // one whole character ending at byte offset end_at
    function automatic void count_char(input logic [20:0] cp, input logic [17:0] end_at);
        logic [17:0] w;
        logic [17:0] keep;
        w = (cp > 21'h0FFFF) ? 18'd2 : 18'd1;
        keep = 18'((limit_shadow < u8cw_pkg::ELLIPSIS_MIN) ? limit_shadow :
                   limit_shadow - u8cw_pkg::KEEP_MARGIN);
        if (limit_shadow != 16'd0 && !cut_done)
        begin
            if (18'(units) + w <= keep)
                cut_at = sat16(end_at);
            else
                cut_done = 1'b1;
        end
        units = sat16(18'(units) + w);
        columns = sat16(18'(columns) + w + (wide_char(cp) ? 18'd1 : 18'd0));
    endfunction

    // an open sequence falls apart into one-unit characters
    function automatic void split_open();
        if (open_need == 2'd0)
            return;
        count_char({13'd0, open_lead}, 18'(open_from) + 18'd1);
        for (int i = 0; i < open_seen; i++)
            count_char(u8cw_pkg::CONT_CHAR, 18'(open_from) + 18'd2 + 18'(i));
        clear_open();
    endfunction

    function automatic void fold_byte(input logic [7:0] b);
        if (open_need != 2'd0)
        begin
            if ((b & u8cw_pkg::CONT_MASK) == u8cw_pkg::CONT_TAG)
            begin
                open_code = {open_code[14:0], b[5:0]};
                open_seen++;
                if (open_seen == open_need)
                begin
                    count_char(open_code, 18'(byte_pos) + 18'd1);
                    clear_open();
                end
                byte_pos = sat16(18'(byte_pos) + 18'd1);
                return;
            end
            split_open();
        end
        if (b >= u8cw_pkg::LEAD2_MIN && b <= u8cw_pkg::LEAD2_MAX)
        begin
            open_need = u8cw_pkg::NEED_TWO;
            open_code = {16'd0, b[4:0]};
        end
        else if (b >= u8cw_pkg::LEAD3_MIN && b <= u8cw_pkg::LEAD3_MAX)
        begin
            open_need = u8cw_pkg::NEED_THREE;
            open_code = {17'd0, b[3:0]};
        end
        else if (b >= u8cw_pkg::LEAD4_MIN && b <= u8cw_pkg::LEAD4_MAX)
        begin
            open_need = u8cw_pkg::NEED_FOUR;
            open_code = {18'd0, b[2:0]};
        end
        else
            count_char({13'd0, b}, 18'(byte_pos) + 18'd1);
        if (open_need != 2'd0)
        begin
            open_lead = b;
            open_seen = 2'd0;
            open_from = byte_pos;
        end
        byte_pos = sat16(18'(byte_pos) + 18'd1);
    endfunction

    // returns 1 when the request closes the cell, with its widths in res
    function automatic logic fold_request(input byte_req_t r, output cell_width_t res);
        logic cut;
        if (r.byte_valid)
            fold_byte(r.text_byte);
        if (!r.last)
            return 1'b0;
        split_open();
        cut = (limit_shadow != 16'd0) && (units > limit_shadow);
        res.display_width = columns;
        res.utf16_length = units;
        res.truncated = cut;
        res.kept_bytes = cut ? cut_at : byte_pos;
        res.add_ellipsis = cut && (limit_shadow >= u8cw_pkg::ELLIPSIS_MIN);
        clear_cell();
        return 1'b1;
    endfunction

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: cell %0d %s expected %0d actual %0d", $time, cells_checked, name,
                     want, got);
        end
    endtask

    task automatic check_cell_width(input cell_width_t got);
        cell_width_t want;
        cells_checked++;
        if (expected_widths.size() == 0)
        begin
            errors++;
            $display("%0t: cell %0d result with no cell pending, width %0d units %0d", $time,
                     cells_checked, got.display_width, got.utf16_length);
        end
        else
        begin
            want = expected_widths.pop_front();
            compare_field("display_width", want.display_width, got.display_width);
            compare_field("utf16_length", want.utf16_length, got.utf16_length);
            compare_field("truncated", 16'(want.truncated), 16'(got.truncated));
            compare_field("kept_bytes", want.kept_bytes, got.kept_bytes);
            compare_field("add_ellipsis", 16'(want.add_ellipsis), 16'(got.add_ellipsis));
        end
    endtask

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(20, 60);
        return $urandom_range(1, 3);
    endfunction

    function automatic int pick_pct();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 10;
            2:       return 40;
            default: return 75;
        endcase
    endfunction

    // request driver
    always @(negedge clk)
    begin
        if (rst_n !== 1'b1)
        begin
            byte_ch.valid <= 1'b0;
            byte_ch.text_byte <= 8'd0;
            byte_ch.byte_valid <= 1'b0;
            byte_ch.last <= 1'b0;
            src_gap = 0;
        end
        else if (!byte_ch.valid || req_fire)
        begin
            if (src_gap > 0)
            begin
                src_gap--;
                byte_ch.valid <= 1'b0;
            end
            else if (pending_reqs.size() != 0)
            begin
                drv_req = pending_reqs.pop_front();
                byte_ch.valid <= 1'b1;
                byte_ch.text_byte <= drv_req.text_byte;
                byte_ch.byte_valid <= drv_req.byte_valid;
                byte_ch.last <= drv_req.last;
                src_gap = ($urandom_range(0, 99) < src_idle_pct) ? pick_gap() : 0;
            end
            else
                byte_ch.valid <= 1'b0;
        end
    end

    // result back-pressure
    always @(negedge clk)
    begin
        if (rst_n !== 1'b1)
        begin
            result_ch.ready <= 1'b0;
            sink_stall = 0;
        end
        else if (sink_stall > 0)
        begin
            sink_stall--;
            result_ch.ready <= 1'b0;
        end
        else if ($urandom_range(0, 99) < sink_stall_pct)
        begin
            sink_stall = pick_gap() - 1;
            result_ch.ready <= 1'b0;
        end
        else
            result_ch.ready <= 1'b1;
    end

    // monitor: checks results, predicts on every accepted request
    always @(posedge clk)
    begin
        if (rst_n !== 1'b1)
            req_fire <= 1'b0;
        else
        begin
            req_fire <= byte_ch.valid && byte_ch.ready;
            if (result_ch.valid && result_ch.ready)
                check_cell_width('{display_width: result_ch.display_width,
                                   utf16_length: result_ch.utf16_length,
                                   truncated: result_ch.truncated,
                                   kept_bytes: result_ch.kept_bytes,
                                   add_ellipsis: result_ch.add_ellipsis});
            if (byte_ch.valid && byte_ch.ready)
            begin
                mon_req.text_byte = byte_ch.text_byte;
                mon_req.byte_valid = byte_ch.byte_valid;
                mon_req.last = byte_ch.last;
                if (fold_request(mon_req, mon_width))
                    expected_widths.insert(expected_widths.size(), mon_width);
            end
        end
    end

    function automatic void queue_req(input logic [7:0] b, input logic v, input logic l);
        byte_req_t r;
        r.text_byte = b;
        r.byte_valid = v;
        r.last = l;
        cell_buf.insert(cell_buf.size(), r);
    endfunction

    function automatic void put_byte(input logic [7:0] b);
        queue_req(b, 1'b1, 1'b0);
    endfunction

    function automatic void put_cont();
        put_byte(8'h80 | 8'($urandom_range(0, 63)));
    endfunction

    function automatic void put_code3(input logic [15:0] cp);
        put_byte({4'hE, cp[15:12]});
        put_byte({2'b10, cp[11:6]});
        put_byte({2'b10, cp[5:0]});
    endfunction

    // last goes on the final byte, or on a separate empty close
    function automatic void close_cell(input logic separate);
        if (separate || cell_buf.size() == 0 || !cell_buf[cell_buf.size() - 1].byte_valid)
            queue_req(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        else
            cell_buf[cell_buf.size() - 1].last = 1'b1;
        queued_items += cell_buf.size();
        while (cell_buf.size() != 0)
            pending_reqs.insert(pending_reqs.size(), cell_buf.pop_front());
    endfunction

    function automatic void add_random_char();
        int kind;
        int need;
        int k;
        int n_cont;
        logic [15:0] cp;
        kind = $urandom_range(0, 99);
        if (kind < 30)
            put_byte(8'($urandom_range(0, 127)));
        else if (kind < 42)
        begin
            put_byte(8'($urandom_range(u8cw_pkg::LEAD2_MIN, u8cw_pkg::LEAD2_MAX)));
            put_cont();
        end
        else if (kind < 62)
        begin
            if ($urandom_range(0, 1) == 1)
            begin
                // full-width ranges and their neighbours
                k = $urandom_range(0, 7);
                case ($urandom_range(0, 3))
                    0:       cp = range_lo(k) - 16'd1;
                    1:       cp = range_hi(k) + 16'd1;
                    default: cp = 16'($urandom_range(range_lo(k), range_hi(k)));
                endcase
                put_code3(cp);
            end
            else
            begin
                put_byte(8'($urandom_range(u8cw_pkg::LEAD3_MIN, u8cw_pkg::LEAD3_MAX)));
                put_cont();
                put_cont();
            end
        end
        else if (kind < 74)
        begin
            put_byte(8'($urandom_range(u8cw_pkg::LEAD4_MIN, u8cw_pkg::LEAD4_MAX)));
            put_cont();
            put_cont();
            put_cont();
        end
        else if (kind < 86)
        begin
            // sequence broken off before its final continuation byte
            need = $urandom_range(1, 3);
            case (need)
                1:       put_byte(8'($urandom_range(u8cw_pkg::LEAD2_MIN, u8cw_pkg::LEAD2_MAX)));
                2:       put_byte(8'($urandom_range(u8cw_pkg::LEAD3_MIN, u8cw_pkg::LEAD3_MAX)));
                default: put_byte(8'($urandom_range(u8cw_pkg::LEAD4_MIN, u8cw_pkg::LEAD4_MAX)));
            endcase
            n_cont = $urandom_range(0, need - 1);
            for (k = 0; k < n_cont; k++)
                put_cont();
        end
        else
            put_byte(8'($urandom_range(0, 255)));
    endfunction

    function automatic void add_random_cell(input int max_chars);
        int n;
        n = $urandom_range(0, max_chars);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 19) == 0)
                queue_req(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            add_random_char();
        end
        close_cell($urandom_range(0, 3) == 0);
    endfunction

    function automatic logic [15:0] phase_limit(input int p);
        case (p)
            0:       return 16'd1;
            1:       return 16'd2;
            2:       return 16'd3;
            3:       return 16'd4;
            4:       return 16'd5;
            5:       return 16'd0;
            6:       return 16'd7;
            7:       return 16'd16;
            8:       return 16'($urandom_range(6, 30));
            default: return 16'hFFFF;
        endcase
    endfunction

    // cells a little longer than the limit so the cut lands near it
    function automatic int chars_for(input logic [15:0] lim);
        return (lim == 16'd0 || lim > 16'd30) ? 14 : int'(lim) + 6;
    endfunction

    task automatic wait_idle();
        do
        begin
            @(posedge clk);
            #1;
        end
        while (pending_reqs.size() != 0 || byte_ch.valid || expected_widths.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [15:0] v);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {u8cw_pkg::REG_TRUNCATE_LIMIT, 2'b00};
        pwdata <= {16'd0, v};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        limit_shadow = v;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic read_limit();
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {u8cw_pkg::REG_TRUNCATE_LIMIT, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        if (prdata[15:0] !== limit_shadow)
        begin
            errors++;
            $display("%0t: truncate_limit read expected %0d actual %0d", $time, limit_shadow,
                     prdata[15:0]);
        end
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    initial
    begin
        int p;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        limit_shadow = u8cw_pkg::LIMIT_RESET;
        clear_cell();

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed cells under the reset limit
        read_limit();
        src_idle_pct = 30;
        sink_stall_pct = 30;
        put_byte(8'h41);
        close_cell(1'b0);
        close_cell(1'b0);
        queue_req(8'hFF, 1'b0, 1'b0);
        put_byte(8'h7F);
        close_cell(1'b0);
        // two, three and four byte forms, full-width and above the basic plane
        put_byte(8'hC3);
        put_byte(8'hA9);
        put_code3(16'h4E00);
        put_byte(8'hF0);
        put_byte(8'h9F);
        put_byte(8'h98);
        put_byte(8'h80);
        close_cell(1'b0);
        // invalid leads, a stray continuation and a zero byte
        put_byte(8'hC0);
        put_byte(8'hFF);
        put_byte(8'h80);
        put_byte(8'h00);
        close_cell(1'b0);
        // broken sequence
        put_byte(8'hE4);
        put_byte(8'h41);
        close_cell(1'b0);
        // sequence cut off at the close
        put_byte(8'hF4);
        put_byte(8'h8F);
        put_byte(8'hBF);
        close_cell(1'b0);

        // random phases, each under its own limit; the sender holds until all are back
        for (p = 0; p < NUM_PHASES; p++)
        begin
            wait_idle();
            write_limit(phase_limit(p));
            read_limit();
            src_idle_pct = pick_pct();
            sink_stall_pct = pick_pct();
            queued_items = 0;
            while (queued_items < PHASE_ITEMS)
                add_random_cell(chars_for(limit_shadow));
        end

        wait_idle();
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #8000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
